FILE: src/spd_pkg.sv
// spd_pkg: shared constants, types, state encodings and the exp table of the
// spectral peak dissonance unit. Depends on nothing; used by all src files.
`default_nettype none
package spd_pkg;

   localparam int MAX_PEAKS   = 128;
   localparam int PAIR_WINDOW = 20;
   localparam int MAX_BINS    = 16384;
   localparam int PEAK_AW     = $clog2(MAX_PEAKS);
   localparam int CNT_W       = $clog2(MAX_PEAKS + 1);
   localparam int BIN_W       = $clog2(MAX_BINS + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PEAKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORM_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HZ_BIN    = 3'd4;

   typedef struct packed {
      logic [23:0] freq;
      logic [23:0] amp;
   } peak_entry_type;

   typedef struct packed {
      logic [47:0]      prev;
      logic [47:0]      now;
      logic [47:0]      nxt;
      logic [BIN_W-1:0] idx;
      logic [15:0]      hz;
   } peak_req_type;

   typedef enum logic [3:0] {
      T_IDLE, T_SQ_RE, T_SQ_IM, T_EVAL, T_PEAK, T_SHIFT, T_PAIR, T_SCALE, T_RESULT
   } top_state_type;

   typedef enum logic [2:0] {
      P_IDLE, P_DIV, P_MHI, P_MLO, P_SQRT, P_FREQ
   } peak_state_type;

   typedef enum logic [3:0] {
      Q_IDLE, Q_RDI, Q_WI, Q_RDK, Q_WK, Q_DIV, Q_YSET, Q_EXP1, Q_EXP2,
      Q_VV, Q_GHI, Q_GLO, Q_ACC, Q_DONE
   } pair_state_type;

   // exp(-2^(b-16)) in Q24
   function automatic logic [23:0] exp_tab(input logic [4:0] b);
      logic [23:0] v;
      unique case (b)
         5'd0:  v = 24'd16776960;
         5'd1:  v = 24'd16776704;
         5'd2:  v = 24'd16776192;
         5'd3:  v = 24'd16775168;
         5'd4:  v = 24'd16773120;
         5'd5:  v = 24'd16769026;
         5'd6:  v = 24'd16760840;
         5'd7:  v = 24'd16744480;
         5'd8:  v = 24'd16711808;
         5'd9:  v = 24'd16646655;
         5'd10: v = 24'd16517109;
         5'd11: v = 24'd16261035;
         5'd12: v = 24'd15760736;
         5'd13: v = 24'd14805841;
         5'd14: v = 24'd13066109;
         5'd15: v = 24'd10175896;
         5'd16: v = 24'd6171993;
         5'd17: v = 24'd2270549;
         5'd18: v = 24'd307285;
         5'd19: v = 24'd5628;
         default: v = 24'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: src/spd_store.sv
// spd_store: peak frequency and amplitude memory, one write and one read port,
// registered read. Depends on spd_pkg.
`default_nettype none
module spd_store (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [spd_pkg::PEAK_AW-1:0] wr_addr,
   input  wire spd_pkg::peak_entry_type     wr_data,
   input  wire logic [spd_pkg::PEAK_AW-1:0] rd_addr,
   output spd_pkg::peak_entry_type          rd_data
);

   spd_pkg::peak_entry_type mem [spd_pkg::MAX_PEAKS];
   spd_pkg::peak_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/spd_peak.sv
// spd_peak: parabolic refinement of one peak: bit-serial ratio divide,
// split multiply, bit-pair square root and frequency scaling. Depends on spd_pkg.
`default_nettype none
module spd_peak (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire spd_pkg::peak_req_type req,
   output logic                       done,
   output spd_pkg::peak_entry_type    entry
);

   spd_pkg::peak_state_type state_ff, state_in;

   logic [49:0] c_ff;
   logic [47:0] d_ff;
   logic [49:0] rem_ff;
   logic [23:0] r_ff;
   logic [4:0]  cnt_ff;
   logic [47:0] now_ff;
   logic [spd_pkg::BIN_W-1:0] idx_ff;
   logic [15:0] hz_ff;
   logic        up_ff;
   logic [47:0] mhi_ff;
   logic [49:0] v_ff;
   logic [49:0] res_ff;
   logic [49:0] bit_ff;
   logic        done_ff;
   spd_pkg::peak_entry_type entry_ff;

   logic [49:0] div_t;
   logic        div_ge;
   logic [47:0] mlo;
   logic [47:0] extra;
   logic [49:0] rb;
   logic [23:0] off;
   logic [23:0] off_adj;
   logic [39:0] fprod;

   // datapath helpers
   always_comb begin
      div_t   = {rem_ff[48:0], 1'b0};
      div_ge  = (div_t >= c_ff) && (c_ff != '0);
      mlo     = d_ff[23:0] * r_ff;
      extra   = (mhi_ff + {24'd0, mlo[47:24]}) >> 3;
      rb      = res_ff + bit_ff;
      off     = 24'(idx_ff) << 8;
      off_adj = up_ff ? off + {17'd0, r_ff[23:17]} : off - {17'd0, r_ff[23:17]};
      fprod   = off_adj * hz_ff;
   end

   // sequence the refinement steps
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spd_pkg::P_IDLE: if (start) state_in = spd_pkg::P_DIV;
         spd_pkg::P_DIV:  if (cnt_ff == 5'd23) state_in = spd_pkg::P_MHI;
         spd_pkg::P_MHI:  state_in = spd_pkg::P_MLO;
         spd_pkg::P_MLO:  state_in = spd_pkg::P_SQRT;
         spd_pkg::P_SQRT: if (bit_ff == 50'd1) state_in = spd_pkg::P_FREQ;
         spd_pkg::P_FREQ: state_in = spd_pkg::P_IDLE;
         default:         state_in = spd_pkg::P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spd_pkg::P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == spd_pkg::P_FREQ);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         spd_pkg::P_IDLE: begin
            c_ff   <= {1'b0, req.now, 1'b0} - {2'b0, req.prev} - {2'b0, req.nxt};
            d_ff   <= (req.nxt >= req.prev) ? req.nxt - req.prev : req.prev - req.nxt;
            rem_ff <= {2'b0, ((req.nxt >= req.prev) ? req.nxt - req.prev
                                                     : req.prev - req.nxt)};
            r_ff   <= '0;
            cnt_ff <= '0;
            now_ff <= req.now;
            idx_ff <= req.idx;
            hz_ff  <= req.hz;
            up_ff  <= req.nxt > req.prev;
         end
         spd_pkg::P_DIV: begin
            rem_ff <= div_ge ? div_t - c_ff : div_t;
            r_ff   <= {r_ff[22:0], div_ge};
            cnt_ff <= cnt_ff + 5'd1;
         end
         spd_pkg::P_MHI: begin
            mhi_ff <= d_ff[47:24] * r_ff;
         end
         spd_pkg::P_MLO: begin
            v_ff   <= {2'b0, now_ff} + {2'b0, extra};
            res_ff <= '0;
            bit_ff <= 50'd1 << 48;
         end
         spd_pkg::P_SQRT: begin
            if (v_ff >= rb) begin
               v_ff   <= v_ff - rb;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         spd_pkg::P_FREQ: begin
            entry_ff.amp  <= (res_ff > 50'hFFFFFF) ? 24'hFFFFFF : res_ff[23:0];
            entry_ff.freq <= (fprod > 40'hFFFFFF) ? 24'hFFFFFF : fprod[23:0];
         end
         default: begin
         end
      endcase
   end

   assign done  = done_ff;
   assign entry = entry_ff;

endmodule
`default_nettype wire

FILE: src/spd_pair.sv
// spd_pair: walks the peak store at frame end, pairs peaks within an octave
// and accumulates the roughness sum. Depends on spd_pkg.
`default_nettype none
module spd_pair (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [spd_pkg::CNT_W-1:0]   n_peaks,
   output logic [spd_pkg::PEAK_AW-1:0]      rd_addr,
   input  wire spd_pkg::peak_entry_type     rd_data,
   output logic                             done,
   output logic [63:0]                      sum
);

   spd_pkg::pair_state_type state_ff, state_in;

   logic [spd_pkg::CNT_W-1:0] i_ff, k_ff, n_ff;
   logic [23:0] f1_ff, v1_ff, v2_ff;
   logic [29:0] den_ff;
   logic [29:0] rem_ff;
   logic [16:0] nlo_ff;
   logic [16:0] x_ff;
   logic [4:0]  cnt_ff;
   logic [19:0] y1_ff, y2_ff;
   logic [24:0] acc_ff, e1_ff;
   logic [16:0] g_ff;
   logic [47:0] vv_ff;
   logic [40:0] ghi_ff, glo_ff;
   logic [63:0] sum_ff;

   logic        more_i, more_k, brk;
   logic [23:0] dq;
   logic [44:0] num;
   logic [30:0] div_t;
   logic        div_ge;
   logic [48:0] ep;
   logic [24:0] acc_next;
   logic [64:0] term_w;
   logic [64:0] sum_w;

   // loop bounds and datapath helpers
   always_comb begin
      more_i   = (32'(i_ff) + 32'd2) < 32'(n_ff);
      more_k   = ((32'(k_ff) + 32'd1) < 32'(n_ff)) &&
                 ((32'(k_ff) + 32'd1) < (32'(i_ff) + spd_pkg::PAIR_WINDOW));
      brk      = {1'b0, rd_data.freq} > {f1_ff, 1'b0};
      dq       = (rd_data.freq > f1_ff) ? rd_data.freq - f1_ff : 24'd0;
      num      = 45'(29'(dq) * 29'd24) << 16;
      div_t    = {rem_ff, nlo_ff[16]};
      div_ge   = div_t >= {1'b0, den_ff};
      ep       = acc_ff * spd_pkg::exp_tab(cnt_ff);
      acc_next = ep[48:24];
      term_w   = ({ghi_ff, 24'd0} + {24'd0, glo_ff}) >> 16;
      sum_w    = {1'b0, sum_ff} + term_w;
   end

   // walk pairs
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spd_pkg::Q_IDLE: if (start) state_in = (n_peaks < 2) ? spd_pkg::Q_DONE
                                                                : spd_pkg::Q_RDI;
         spd_pkg::Q_RDI:  state_in = spd_pkg::Q_WI;
         spd_pkg::Q_WI:   state_in = spd_pkg::Q_RDK;
         spd_pkg::Q_RDK:  state_in = spd_pkg::Q_WK;
         spd_pkg::Q_WK: begin
            if (!brk)        state_in = spd_pkg::Q_DIV;
            else if (more_i) state_in = spd_pkg::Q_RDI;
            else             state_in = spd_pkg::Q_DONE;
         end
         spd_pkg::Q_DIV:  if (cnt_ff == 5'd16) state_in = spd_pkg::Q_YSET;
         spd_pkg::Q_YSET: state_in = spd_pkg::Q_EXP1;
         spd_pkg::Q_EXP1: if (cnt_ff == 5'd19) state_in = spd_pkg::Q_EXP2;
         spd_pkg::Q_EXP2: if (cnt_ff == 5'd19) state_in = spd_pkg::Q_VV;
         spd_pkg::Q_VV:   state_in = spd_pkg::Q_GHI;
         spd_pkg::Q_GHI:  state_in = spd_pkg::Q_GLO;
         spd_pkg::Q_GLO:  state_in = spd_pkg::Q_ACC;
         spd_pkg::Q_ACC: begin
            if (more_k)      state_in = spd_pkg::Q_RDK;
            else if (more_i) state_in = spd_pkg::Q_RDI;
            else             state_in = spd_pkg::Q_DONE;
         end
         spd_pkg::Q_DONE: state_in = spd_pkg::Q_IDLE;
         default:         state_in = spd_pkg::Q_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= spd_pkg::Q_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         unique case (state_ff)
            spd_pkg::Q_IDLE: begin
               if (start) begin
                  sum_ff <= '0;
                  i_ff   <= '0;
                  n_ff   <= n_peaks;
               end
            end
            spd_pkg::Q_WI: begin
               f1_ff  <= rd_data.freq;
               v1_ff  <= rd_data.amp;
               den_ff <= 30'(rd_data.freq) * 30'd21 + 30'd486400;
               k_ff   <= i_ff + 1'b1;
            end
            spd_pkg::Q_WK: begin
               if (brk) begin
                  i_ff <= i_ff + 1'b1;
               end
               v2_ff  <= rd_data.amp;
               rem_ff <= {2'b0, num[44:17]};
               nlo_ff <= num[16:0];
               x_ff   <= '0;
               cnt_ff <= '0;
            end
            spd_pkg::Q_DIV: begin
               rem_ff <= div_ge ? 30'(div_t - {1'b0, den_ff}) : div_t[29:0];
               nlo_ff <= {nlo_ff[15:0], 1'b0};
               x_ff   <= {x_ff[15:0], div_ge};
               cnt_ff <= cnt_ff + 5'd1;
            end
            spd_pkg::Q_YSET: begin
               y1_ff  <= 20'((20'(x_ff) * 20'd7) >> 1);
               y2_ff  <= 20'((22'(x_ff) * 22'd23) >> 2);
               acc_ff <= 25'd1 << 24;
               cnt_ff <= '0;
            end
            spd_pkg::Q_EXP1: begin
               if (cnt_ff == 5'd19) begin
                  e1_ff  <= y1_ff[cnt_ff] ? acc_next : acc_ff;
                  acc_ff <= 25'd1 << 24;
                  cnt_ff <= '0;
               end else begin
                  if (y1_ff[cnt_ff]) acc_ff <= acc_next;
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            spd_pkg::Q_EXP2: begin
               if (y2_ff[cnt_ff]) acc_ff <= acc_next;
               cnt_ff <= cnt_ff + 5'd1;
            end
            spd_pkg::Q_VV: begin
               // difference of the two exponentials, Q16
               g_ff  <= (e1_ff > acc_ff) ? 17'((e1_ff - acc_ff) >> 8) : 17'd0;
               vv_ff <= v1_ff * v2_ff;
            end
            spd_pkg::Q_GHI: ghi_ff <= vv_ff[47:24] * g_ff;
            spd_pkg::Q_GLO: glo_ff <= vv_ff[23:0] * g_ff;
            spd_pkg::Q_ACC: begin
               sum_ff <= sum_w[64] ? '1 : sum_w[63:0];
               if (more_k) k_ff <= k_ff + 1'b1;
               else        i_ff <= i_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_addr = (state_ff == spd_pkg::Q_RDI) ? i_ff[spd_pkg::PEAK_AW-1:0]
                                                  : k_ff[spd_pkg::PEAK_AW-1:0];
   assign done = (state_ff == spd_pkg::Q_DONE);
   assign sum  = sum_ff;

endmodule
`default_nettype wire

FILE: src/spectral_peak_dissonance_unit.sv
// spectral_peak_dissonance_unit: top level; bin intake, peak detection control,
// configuration registers and result scaling. Depends on spd_pkg, spd_store,
// spd_peak and spd_pair.
//
//   channel   ports                               transfer
//   -------   ---------------------------------   ---------------------------
//   request   start, busy, req_bin_*, req_last    start high while busy low
//   result    rsp_strobe, rsp_dissonance          strobe high, one cycle
//   config    csr_wr_en, csr_index, csr_wr_data   wr_en high, no wait
//
// A bin without a peak passes two power multiplies, a compare and a shift; a peak
// adds a 24-step ratio divide, a split multiply and a 25-step square root.
// The last bin adds pairing: a row read per peak, per pair a 17-step divide and two
// 20-step exp products, a row break at the octave, then scaling and the result.
// Reset is synchronous and clears control state; the peak store needs no clear.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module spectral_peak_dissonance_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [23:0]              req_bin_real,
   input  wire logic signed [23:0]              req_bin_imag,
   input  wire logic                            req_last_bin,
   output logic                                 rsp_strobe,
   output logic [31:0]                          rsp_dissonance,
   input  wire logic                            csr_wr_en,
   input  wire logic [spd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [47:0]                     csr_wr_data
);

   spd_pkg::top_state_type state_ff, state_in;

   logic [47:0] threshold_ff;
   logic [7:0]  max_peaks_ff;
   logic [31:0] norm_gain_ff;
   logic [15:0] clamp_ff;
   logic [15:0] hz_ff;

   logic signed [23:0] re_ff, im_ff;
   logic        last_ff;
   logic [47:0] sq_ff, pow_ff, prev_ff, now_ff;
   logic [spd_pkg::BIN_W-1:0] bin_cnt_ff;
   logic [spd_pkg::CNT_W-1:0] peak_cnt_ff;
   logic [63:0] prod_ff;
   logic        rsp_strobe_ff;
   logic [31:0] rsp_data_ff;

   logic signed [47:0] re_sq, im_sq;
   logic [spd_pkg::CNT_W-1:0] peak_lim;
   logic        in_range, is_peak;
   logic        peak_start, peak_done, pair_start, pair_done;
   spd_pkg::peak_req_type   peak_req;
   spd_pkg::peak_entry_type peak_entry, rd_data;
   logic [spd_pkg::PEAK_AW-1:0] rd_addr;
   logic [63:0] diss_sum;
   logic [31:0] limit;
   logic [31:0] res;

   // power terms and peak test
   always_comb begin
      re_sq    = re_ff * re_ff;
      im_sq    = im_ff * im_ff;
      peak_lim = (32'(max_peaks_ff) > 32'(spd_pkg::MAX_PEAKS))
                 ? spd_pkg::CNT_W'(spd_pkg::MAX_PEAKS) : spd_pkg::CNT_W'(max_peaks_ff);
      in_range = bin_cnt_ff < spd_pkg::BIN_W'(spd_pkg::MAX_BINS);
      is_peak  = (bin_cnt_ff >= spd_pkg::BIN_W'(2)) && (peak_cnt_ff < peak_lim) &&
                 (now_ff > threshold_ff) && (now_ff > prev_ff) && (now_ff > pow_ff);
      peak_req.prev = prev_ff;
      peak_req.now  = now_ff;
      peak_req.nxt  = pow_ff;
      peak_req.idx  = bin_cnt_ff;
      peak_req.hz   = hz_ff;
      limit = {clamp_ff, 16'd0};
      if (norm_gain_ff == '0)          res = '0;
      else if (diss_sum[63:32] != '0)  res = limit;
      else if (prod_ff > {32'd0, limit}) res = limit;
      else                             res = prod_ff[31:0];
   end

   // bin sequencer: next state and unit starts
   always_comb begin
      state_in   = state_ff;
      peak_start = 1'b0;
      pair_start = 1'b0;
      unique case (state_ff)
         spd_pkg::T_IDLE:  if (start) state_in = spd_pkg::T_SQ_RE;
         spd_pkg::T_SQ_RE: state_in = spd_pkg::T_SQ_IM;
         spd_pkg::T_SQ_IM: state_in = spd_pkg::T_EVAL;
         spd_pkg::T_EVAL: begin
            priority if (in_range && is_peak) begin
               peak_start = 1'b1;
               state_in   = spd_pkg::T_PEAK;
            end else if (in_range) begin
               state_in = spd_pkg::T_SHIFT;
            end else if (last_ff) begin
               pair_start = 1'b1;
               state_in   = spd_pkg::T_PAIR;
            end else begin
               state_in = spd_pkg::T_IDLE;
            end
         end
         spd_pkg::T_PEAK:  if (peak_done) state_in = spd_pkg::T_SHIFT;
         spd_pkg::T_SHIFT: begin
            if (last_ff) begin
               pair_start = 1'b1;
               state_in   = spd_pkg::T_PAIR;
            end else begin
               state_in = spd_pkg::T_IDLE;
            end
         end
         spd_pkg::T_PAIR:   if (pair_done) state_in = spd_pkg::T_SCALE;
         spd_pkg::T_SCALE:  state_in = spd_pkg::T_RESULT;
         spd_pkg::T_RESULT: state_in = spd_pkg::T_IDLE;
         default:           state_in = spd_pkg::T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= spd_pkg::T_IDLE;
      else       state_ff <= state_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         max_peaks_ff <= 8'd100;
         norm_gain_ff <= 32'd655;
         clamp_ff     <= 16'd1;
         hz_ff        <= 16'd43;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            spd_pkg::CSR_THRESHOLD: threshold_ff <= csr_wr_data;
            spd_pkg::CSR_MAX_PEAKS: max_peaks_ff <= csr_wr_data[7:0];
            spd_pkg::CSR_NORM_GAIN: norm_gain_ff <= csr_wr_data[31:0];
            spd_pkg::CSR_CLAMP:     clamp_ff     <= csr_wr_data[15:0];
            spd_pkg::CSR_HZ_BIN:    hz_ff        <= csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // frame state and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         now_ff        <= '0;
         bin_cnt_ff    <= '0;
         peak_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == spd_pkg::T_RESULT);
         unique case (state_ff)
            spd_pkg::T_IDLE: begin
               if (start) begin
                  re_ff   <= req_bin_real;
                  im_ff   <= req_bin_imag;
                  last_ff <= req_last_bin;
               end
            end
            spd_pkg::T_SQ_RE: sq_ff  <= $unsigned(re_sq);
            spd_pkg::T_SQ_IM: pow_ff <= sq_ff + $unsigned(im_sq);
            spd_pkg::T_EVAL:  if (in_range) bin_cnt_ff <= bin_cnt_ff + 1'b1;
            spd_pkg::T_PEAK:  if (peak_done) peak_cnt_ff <= peak_cnt_ff + 1'b1;
            spd_pkg::T_SHIFT: begin
               prev_ff <= now_ff;
               now_ff  <= pow_ff;
            end
            spd_pkg::T_SCALE: prod_ff <= diss_sum[31:0] * norm_gain_ff;
            spd_pkg::T_RESULT: begin
               rsp_data_ff   <= res;
               prev_ff       <= '0;
               now_ff        <= '0;
               bin_cnt_ff    <= '0;
               peak_cnt_ff   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   spd_store u_store (
      .clock   (clock),
      .wr_en   ((state_ff == spd_pkg::T_PEAK) && peak_done),
      .wr_addr (peak_cnt_ff[spd_pkg::PEAK_AW-1:0]),
      .wr_data (peak_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spd_peak u_peak (
      .clock (clock),
      .reset (reset),
      .start (peak_start),
      .req   (peak_req),
      .done  (peak_done),
      .entry (peak_entry)
   );

   spd_pair u_pair (
      .clock   (clock),
      .reset   (reset),
      .start   (pair_start),
      .n_peaks (peak_cnt_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (pair_done),
      .sum     (diss_sum)
   );

   assign busy           = (state_ff != spd_pkg::T_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_dissonance = rsp_data_ff;

endmodule
`default_nettype wire
